// File: hw/rtl/sbsh_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// Used by sbsh_ctrl, sbsh_dp and sha256_byte_stream_hasher; depends on nothing.
package sbsh_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 64;
	localparam int unsigned FILL_W = 6;
	localparam int unsigned RND_W  = 6;
	localparam int unsigned IDX_W  = 3;

	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
	localparam logic [RND_W-1:0]  RND_LAST  = 6'd63;
	localparam logic [IDX_W-1:0]  IDX_LAST  = 3'd7;

	// byte source of a block push
	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic             push;
		logic [1:0]       byte_sel;
		logic             load_work;
		logic             round;
		logic             add_hash;
		logic             restart;
		logic [RND_W-1:0] rnd;
		logic [IDX_W-1:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic blk_done;
		logic at_len;
	} sts_t;

	function automatic word_t h_init(input logic [IDX_W-1:0] i);
		word_t v;
		case (i)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			3'd7: v = 32'h5be0cd19;
			default: v = 32'h6a09e667;
		endcase
		return v;
	endfunction

	function automatic word_t k_const(input logic [RND_W-1:0] t);
		word_t v;
		case (t)
			6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
			default: v = 32'h428a2f98;
		endcase
		return v;
	endfunction

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// File: hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream; top level joining sbsh_ctrl and sbsh_dp (sbsh_pkg).
// Throughput: one byte per cycle while idle; the 64th byte of a block closes input until
// that block is compressed (load, 64 rounds on one shared round unit, hash add).
// Message end: one pad byte per cycle up to the 56th slot or the next block, each
// block compressed as above, then eight digest words, one per accepted request.
// Reset (arst_n low, asynchronous): initial hash values, empty block, zero length.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [2:0]  m_tuser,  // [2:0] word_index
	output logic        m_tlast   // last_word
);

	sbsh_pkg::cmd_t cmd;
	sbsh_pkg::sts_t sts;

	sbsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sbsh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.digest    (m_tdata)
	);

	assign m_tuser = cmd.out_idx;
	assign m_tlast = (cmd.out_idx == sbsh_pkg::IDX_LAST);

endmodule

// File: hw/rtl/sbsh_ctrl.sv
// Controller of the SHA-256 byte stream hasher: handshakes, padding sequence,
// round counter and digest readout. Depends on sbsh_pkg.
module sbsh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tlast,
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sbsh_pkg::cmd_t      cmd,
	input  sbsh_pkg::sts_t      sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_PAD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic [1:0] P_80   = 2'd0;
	localparam logic [1:0] P_ZERO = 2'd1;
	localparam logic [1:0] P_LEN  = 2'd2;

	logic [2:0]                     state_q, state_d;
	logic [1:0]                     pad_q, pad_d;
	logic                           fin_q, fin_d;
	logic [sbsh_pkg::RND_W-1:0]     rnd_q, rnd_d;
	logic [sbsh_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic                           s_req, m_req;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign s_req    = s_tvalid && s_tready;
	assign m_req    = m_tvalid && m_tready;

	always_comb begin
		state_d      = state_q;
		pad_d        = pad_q;
		fin_d        = fin_q;
		rnd_d        = rnd_q;
		idx_d        = idx_q;
		cmd          = '0;
		cmd.rnd      = rnd_q;
		cmd.out_idx  = idx_q;
		cmd.byte_sel = sbsh_pkg::SEL_DATA;
		case (state_q)
			ST_IDLE: begin
				if (s_req) begin
					cmd.push = s_tuser;
					if (s_tlast) begin
						fin_d = 1'b1;
						pad_d = P_80;
					end
					if (s_tuser && sts.blk_done) begin
						state_d = ST_LOAD;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_work = 1'b1;
				rnd_d         = '0;
				state_d       = ST_RND;
			end
			ST_RND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 1'b1;
				if (rnd_q == sbsh_pkg::RND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_hash = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (pad_q == P_LEN) begin
					idx_d   = '0;
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				case (pad_q)
					P_80: begin
						cmd.byte_sel = sbsh_pkg::SEL_PAD;
						pad_d        = P_ZERO;
					end
					P_ZERO: begin
						if (sts.at_len) begin
							cmd.byte_sel = sbsh_pkg::SEL_LEN;
							pad_d        = P_LEN;
						end else begin
							cmd.byte_sel = sbsh_pkg::SEL_ZERO;
						end
					end
					default: begin
						cmd.byte_sel = sbsh_pkg::SEL_LEN;
					end
				endcase
				if (sts.blk_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_OUT: begin
				if (m_req) begin
					idx_d = idx_q + 1'b1;
					if (idx_q == sbsh_pkg::IDX_LAST) begin
						cmd.restart = 1'b1;
						fin_d       = 1'b0;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q   <= P_80;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			fin_q   <= fin_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	a_rnd_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && rnd_q != sbsh_pkg::RND_LAST) |=>
		(state_q == ST_RND && rnd_q == $past(rnd_q) + 1'b1))
		else $error("round counter skipped");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && fin_q && pad_q == P_LEN) |=> (state_q == ST_OUT))
		else $error("final block did not lead to readout");

	a_out_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> fin_q)
		else $error("readout without message end");

endmodule

// File: hw/rtl/sbsh_dp.sv
// Datapath of the SHA-256 byte stream hasher: byte window, message schedule,
// working variables, hash words and length count. Depends on sbsh_pkg.
module sbsh_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sbsh_pkg::BYTE_W-1:0]         data_byte,
	input  sbsh_pkg::cmd_t                      cmd,
	output sbsh_pkg::sts_t                      sts,
	output sbsh_pkg::word_t                     digest
);

	sbsh_pkg::word_t                win_q [16];
	sbsh_pkg::word_t                wv_q  [8];
	sbsh_pkg::word_t                hv_q  [8];
	logic [sbsh_pkg::FILL_W-1:0]    fill_q;
	logic [sbsh_pkg::LEN_W-1:0]     bits_q;

	logic [sbsh_pkg::BYTE_W-1:0]    push_byte;
	logic [2:0]                     len_sel;
	sbsh_pkg::word_t                w_new, t1, t2, ch, maj;

	assign sts.blk_done = (fill_q == sbsh_pkg::FILL_LAST);
	assign sts.at_len   = (fill_q == sbsh_pkg::LEN_POS);
	assign digest       = hv_q[cmd.out_idx];

	assign len_sel = ~fill_q[2:0];

	always_comb begin
		case (cmd.byte_sel)
			sbsh_pkg::SEL_DATA: push_byte = data_byte;
			sbsh_pkg::SEL_PAD:  push_byte = sbsh_pkg::PAD_BYTE;
			sbsh_pkg::SEL_ZERO: push_byte = '0;
			sbsh_pkg::SEL_LEN:  push_byte = bits_q[{len_sel, 3'b000} +: 8];
			default:            push_byte = '0;
		endcase
	end

	assign w_new = sbsh_pkg::ssig1(win_q[14]) + win_q[9] + sbsh_pkg::ssig0(win_q[1])
		+ win_q[0];
	assign ch    = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj   = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1    = wv_q[7] + sbsh_pkg::bsig1(wv_q[4]) + ch + sbsh_pkg::k_const(cmd.rnd)
		+ win_q[0];
	assign t2    = sbsh_pkg::bsig0(wv_q[0]) + maj;

	// byte window doubles as the schedule window
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], push_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= hv_q[i];
			end
		end else if (cmd.round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hv_q[i] <= sbsh_pkg::h_init(3'(i));
			end
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) begin
					hv_q[i] <= sbsh_pkg::h_init(3'(i));
				end
				bits_q <= '0;
			end else if (cmd.add_hash) begin
				for (int i = 0; i < 8; i++) begin
					hv_q[i] <= hv_q[i] + wv_q[i];
				end
			end
			if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
				if (cmd.byte_sel == sbsh_pkg::SEL_DATA) begin
					bits_q <= bits_q + 64'd8;
				end
			end
		end
	end

endmodule

// File: verif/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of sha256_byte_stream_hasher: streams byte requests and
// compares the digest words with its own SHA-256 computation; depends on sbsh_pkg.
module sha256_byte_stream_hasher_tb;

	typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} traffic_phase_t;

	typedef struct {
		logic [7:0]     data;
		logic           present;
		logic           eom;
		traffic_phase_t phase;
		bit             drain;
	} byte_req_t;

	typedef struct {
		sbsh_pkg::word_t word;
		logic [2:0]      index;
		logic            last;
	} digest_word_t;

	localparam int RAND_REQS = 140;
	localparam int TAIL_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	byte_req_t      pending_reqs[$];
	digest_word_t   digest_q[$];
	traffic_phase_t traffic_phase = PH_STEADY;
	int             mismatches = 0;
	int             reqs_accepted = 0;
	int             messages_hashed = 0;
	int             words_checked = 0;

	sbsh_pkg::word_t hash_state[8];
	logic [7:0]      blk[64];
	int              blk_fill = 0;
	logic [63:0]     bit_count = 64'd0;

	sbsh_pkg::word_t iv[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	sbsh_pkg::word_t round_k[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	sha256_byte_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic sbsh_pkg::word_t ror(input sbsh_pkg::word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic int src_idle_pct(input traffic_phase_t ph);
		case (ph)
			PH_SRC_IDLE: return 57;
			PH_BOTH:     return 34;
			default:     return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(input traffic_phase_t ph);
		case (ph)
			PH_SINK_STALL: return 57;
			PH_BOTH:       return 34;
			default:       return 0;
		endcase
	endfunction

	task automatic compress_block();
		sbsh_pkg::word_t w[16];
		sbsh_pkg::word_t a, b, c, d, e, f, g, h, t1, t2;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (t = 0; t < 64; t++) begin
			if (t >= 16) begin
				w[t%16] = w[t%16] + w[(t+9)%16]
					+ (ror(w[(t+1)%16], 7) ^ ror(w[(t+1)%16], 18) ^ (w[(t+1)%16] >> 3))
					+ (ror(w[(t+14)%16], 17) ^ ror(w[(t+14)%16], 19) ^ (w[(t+14)%16] >> 10));
			end
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ round_k[t] + w[t%16];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		blk[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	task automatic hash_step(input byte_req_t req);
		logic [63:0] msg_len;
		digest_word_t dw;
		int i;
		if (req.present) begin
			absorb_byte(req.data);
			bit_count += 64'd8;
		end
		if (req.eom) begin
			msg_len = bit_count;
			absorb_byte(8'h80);
			while (blk_fill != 56)
				absorb_byte(8'h00);
			for (i = 0; i < 8; i++)
				absorb_byte(msg_len[63 - 8*i -: 8]);
			for (i = 0; i < 8; i++) begin
				dw.word = hash_state[i];
				dw.index = 3'(i);
				dw.last = (i == 7);
				digest_q.push_back(dw);
			end
			hash_state = iv;
			blk_fill = 0;
			bit_count = 64'd0;
			messages_hashed++;
		end
	endtask

	task automatic add_req(input logic [7:0] data, input logic present, input logic eom,
			input traffic_phase_t ph, input bit drain);
		byte_req_t r;
		r.data = data;
		r.present = present;
		r.eom = eom;
		r.phase = ph;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	// random bytes with stray idle requests; end either on the last byte or on an empty tail
	task automatic add_message(input int len, input traffic_phase_t ph, input bit drain,
			inout int counted);
		bit empty_tail;
		bit first;
		int i;
		empty_tail = (len == 0) || ($urandom_range(0, 3) == 0);
		first = drain;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, ph, first);
				first = 1'b0;
			end
			add_req(8'($urandom_range(0, 255)), 1'b1, !empty_tail && (i == len - 1), ph, first);
			first = 1'b0;
			counted++;
		end
		if (empty_tail) begin
			add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, ph, first);
			counted++;
		end
	endtask

	always @(posedge clk) begin : src_drive
		bit busy;
		bit hold;
		byte_req_t nxt;
		if (arst_n) begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				hash_step(pending_reqs[0]);
				pending_reqs.pop_front();
				reqs_accepted++;
				busy = 1'b0;
			end
			if (!busy) begin
				hold = 1'b1;
				if (pending_reqs.size() != 0) begin
					nxt = pending_reqs[0];
					hold = (nxt.drain && digest_q.size() != 0)
						|| ($urandom_range(0, 99) < src_idle_pct(nxt.phase));
				end
				if (hold) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tuser <= nxt.present;
					s_tlast <= nxt.eom;
					traffic_phase <= nxt.phase;
				end
			end
		end
	end

	always @(posedge clk) begin : sink_check
		digest_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest_word %h (word_index %0d)", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = digest_q.pop_front();
				words_checked++;
				if (m_tdata !== want.word) begin
					$error("digest_word: expected %h, got %h", want.word, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.index) begin
					$error("word_index: expected %0d, got %0d", want.index, m_tuser);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_word: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct(traffic_phase));
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int counted;
		int len;
		traffic_phase_t ph;
		traffic_phase_t prev_ph;
		int boundary_len[6];
		boundary_len = '{55, 56, 63, 64, 119, 120};
		hash_state = iv;

		add_req(8'hff, 1'b0, 1'b0, PH_STEADY, 1'b0);
		add_req(8'h00, 1'b0, 1'b1, PH_STEADY, 1'b0);
		add_req(8'h00, 1'b1, 1'b1, PH_STEADY, 1'b0);
		add_req(8'hff, 1'b1, 1'b1, PH_STEADY, 1'b0);
		add_req(8'h61, 1'b1, 1'b0, PH_STEADY, 1'b0);
		add_req(8'h62, 1'b1, 1'b0, PH_STEADY, 1'b0);
		add_req(8'h63, 1'b1, 1'b1, PH_STEADY, 1'b0);
		add_req(8'h5a, 1'b1, 1'b0, PH_STEADY, 1'b0);
		add_req(8'ha5, 1'b0, 1'b1, PH_STEADY, 1'b0);
		add_req(8'h01, 1'b1, 1'b0, PH_STEADY, 1'b0);
		add_req(8'h80, 1'b0, 1'b0, PH_STEADY, 1'b0);
		add_req(8'hfe, 1'b1, 1'b1, PH_STEADY, 1'b0);

		counted = 0;
		prev_ph = PH_BOTH;
		while (counted < RAND_REQS) begin
			ph = traffic_phase_t'((counted * 4) / RAND_REQS);
			if ($urandom_range(0, 3) == 0)
				len = boundary_len[$urandom_range(0, 5)];
			else
				len = $urandom_range(0, 9);
			if (len > RAND_REQS - counted)
				len = RAND_REQS - counted;
			add_message(len, ph, ph != prev_ph, counted);
			prev_ph = ph;
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_reqs.size() != 0 || digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Streamed %0d requests forming %0d messages (empty, short and block-boundary",
			reqs_accepted, messages_hashed);
		$display("lengths) under four idle/stall mixes; checked %0d digest words",
			words_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sbsh_dp.sv
hw/rtl/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_tb.sv
